/* rtl/core/mpe_pkg.sv */
// Shared types, constants and the control store of the ellipse outline sequencer.
package mpe_pkg;

    localparam int CW      = 12;  // center coordinate width
    localparam int RW      = 5;   // radius width
    localparam int COORD_W = 14;  // signed output coordinate width
    localparam int SURF_W  = 13;  // surface size register width
    localparam int XY_W    = 8;   // signed step x / step y
    localparam int SLOPE_W = 20;  // signed slope terms
    localparam int DEC_W   = 26;  // signed decision, accumulator and product
    localparam int MUL_W   = 14;  // signed multiplier operand width
    localparam int PC_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 64;
    localparam int M_MASK_LSB = 4 * COORD_W;

    localparam logic [CFG_IDX_W-1:0] REG_SURF_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SURF_HEIGHT = 2'd1;

    typedef logic [PC_W-1:0] upc_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL_RXRX,
        OP_MUL_RYRY,
        OP_MUL_RX2RY,
        OP_INIT1,
        OP_STEP1,
        OP_MUL_X,
        OP_MUL_RY2P,
        OP_MUL_Y,
        OP_MUL_RX2P,
        OP_MUL_RX2RY2,
        OP_INIT2,
        OP_STEP2,
        OP_EMIT_FINAL,
        OP_EMIT_ZERO
    } dp_op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_ZERO_RAD,
        C_R1_END,
        C_R2_END
    } cond_t;

    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        upc_t   target;
        logic   loop;      // stay on this step while cond is false
        logic   wait_in;
        logic   wait_out;
    } uword_t;

    typedef struct packed {
        dp_op_t op;
        logic   exec;
    } dp_ctrl_t;

    typedef struct packed {
        logic zero_rad;
        logic r1_end;
        logic r2_end;
        logic out_free;
    } dp_status_t;

    localparam upc_t UA_IDLE  = 4'd0;
    localparam upc_t UA_R2SET = 4'd6;
    localparam upc_t UA_FINAL = 4'd13;
    localparam upc_t UA_ZERO  = 4'd14;

    function automatic uword_t uw(dp_op_t op, cond_t cond, upc_t target,
                                  logic loop, logic wait_in, logic wait_out);
        uword_t w;
        w.op       = op;
        w.cond     = cond;
        w.target   = target;
        w.loop     = loop;
        w.wait_in  = wait_in;
        w.wait_out = wait_out;
        return w;
    endfunction

    function automatic uword_t ucode_rom(upc_t addr);
        uword_t w;
        case (addr)
            4'd0:    w = uw(OP_LOAD,       C_NEVER,    UA_IDLE,  1'b0, 1'b1, 1'b0);
            4'd1:    w = uw(OP_MUL_RXRX,   C_ZERO_RAD, UA_ZERO,  1'b0, 1'b0, 1'b0);
            4'd2:    w = uw(OP_MUL_RYRY,   C_NEVER,    UA_IDLE,  1'b0, 1'b0, 1'b0);
            4'd3:    w = uw(OP_MUL_RX2RY,  C_NEVER,    UA_IDLE,  1'b0, 1'b0, 1'b0);
            4'd4:    w = uw(OP_INIT1,      C_NEVER,    UA_IDLE,  1'b0, 1'b0, 1'b0);
            4'd5:    w = uw(OP_STEP1,      C_R1_END,   UA_R2SET, 1'b1, 1'b0, 1'b1);
            4'd6:    w = uw(OP_MUL_X,      C_NEVER,    UA_IDLE,  1'b0, 1'b0, 1'b0);
            4'd7:    w = uw(OP_MUL_RY2P,   C_NEVER,    UA_IDLE,  1'b0, 1'b0, 1'b0);
            4'd8:    w = uw(OP_MUL_Y,      C_NEVER,    UA_IDLE,  1'b0, 1'b0, 1'b0);
            4'd9:    w = uw(OP_MUL_RX2P,   C_NEVER,    UA_IDLE,  1'b0, 1'b0, 1'b0);
            4'd10:   w = uw(OP_MUL_RX2RY2, C_NEVER,    UA_IDLE,  1'b0, 1'b0, 1'b0);
            4'd11:   w = uw(OP_INIT2,      C_NEVER,    UA_IDLE,  1'b0, 1'b0, 1'b0);
            4'd12:   w = uw(OP_STEP2,      C_R2_END,   UA_FINAL, 1'b1, 1'b0, 1'b1);
            4'd13:   w = uw(OP_EMIT_FINAL, C_ALWAYS,   UA_IDLE,  1'b0, 1'b0, 1'b1);
            4'd14:   w = uw(OP_EMIT_ZERO,  C_ALWAYS,   UA_IDLE,  1'b0, 1'b0, 1'b1);
            default: w = uw(OP_NOP,        C_ALWAYS,   UA_IDLE,  1'b0, 1'b0, 1'b0);
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/mpe_seq.sv */
// Microcode sequencer: step counter, control store lookup, stalls and jumps.
module mpe_seq
    import mpe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  dp_status_t status,
    output dp_ctrl_t   ctrl,
    output logic       s_tready
);

    upc_t   pc_reg, pc_next;
    uword_t word;
    logic   cond_true;
    logic   stall;

    assign word = ucode_rom(pc_reg);

    always_comb begin
        unique case (word.cond)
            C_NEVER:    cond_true = 1'b0;
            C_ALWAYS:   cond_true = 1'b1;
            C_ZERO_RAD: cond_true = status.zero_rad;
            C_R1_END:   cond_true = status.r1_end;
            C_R2_END:   cond_true = status.r2_end;
            default:    cond_true = 1'b1;
        endcase
    end

    // a loop step that is about to exit does not need the output register
    assign stall = (word.wait_in && !s_tvalid) ||
                   (word.wait_out && !status.out_free && !(word.loop && cond_true));

    assign ctrl.op   = word.op;
    assign ctrl.exec = !stall && !(word.loop && cond_true);
    assign s_tready  = word.wait_in;

    always_comb begin
        priority if (stall) begin
            pc_next = pc_reg;
        end else if (cond_true) begin
            pc_next = word.target;
        end else if (word.loop) begin
            pc_next = pc_reg;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= UA_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* rtl/core/mpe_dp.sv */
// Ellipse datapath: held request, shared multiplier, decision update, clipping, result register.
module mpe_dp
    import mpe_pkg::*;
#(
    parameter int RADIUS_MAX  = 31,
    parameter int SURFACE_MAX = 4096
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dp_ctrl_t               ctrl,
    output dp_status_t             status,
    input  logic [CW-1:0]          center_x,
    input  logic [CW-1:0]          center_y,
    input  logic [RW-1:0]          radius_x,
    input  logic [RW-1:0]          radius_y,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [SURF_W-1:0]      cfg_wdata,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic signed [COORD_W-1:0] right_col,
    output logic signed [COORD_W-1:0] left_col,
    output logic signed [COORD_W-1:0] lower_row,
    output logic signed [COORD_W-1:0] upper_row,
    output logic [3:0]             point_mask,
    output logic                   last_point_group
);

    localparam int RCMP_W = ($clog2(RADIUS_MAX + 1) > RW) ? $clog2(RADIUS_MAX + 1) : RW;
    localparam int CAP    = 2 * RADIUS_MAX + 1;
    localparam int N_W    = $clog2(CAP + 1);
    localparam int SW_W   = $clog2(SURFACE_MAX + 1);
    localparam int CMP_W  = (SW_W > SURF_W) ? SW_W : SURF_W;
    localparam logic signed [XY_W-1:0] XY_ONE = XY_W'(1);

    // held request and loop state
    logic [CW-1:0]              cx_reg, cy_reg;
    logic [RW-1:0]              rx_reg, ry_reg;
    logic [2*RW-1:0]            rx2_reg, ry2_reg;
    logic signed [XY_W-1:0]     x_reg, y_reg;
    logic signed [SLOPE_W-1:0]  px_reg, py_reg;
    logic signed [DEC_W-1:0]    p_reg, acc_reg, prod_reg;
    logic [N_W-1:0]             n_reg;
    logic [SW_W-1:0]            width_reg, height_reg;

    logic                       m_valid_reg;
    logic signed [COORD_W-1:0]  right_reg, left_reg, lower_reg, upper_reg;
    logic [3:0]                 mask_reg;
    logic                       last_reg;

    // multiplier
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [2*MUL_W-1:0]  mul_p;
    logic signed [DEC_W-1:0]    prod_next;

    logic signed [MUL_W-1:0]    rx_m, ry_m, rx2_m, ry2_m, x2p1_m, ym1_m, prod_m;
    logic signed [DEC_W-1:0]    rx2_d, ry2_d, px_nd, py_nd, prod_x4;
    logic signed [SLOPE_W-1:0]  rx2x2, ry2x2, px_next, py_next;
    logic signed [DEC_W-1:0]    p1_lo, p1_hi, p2_hi, p2_lo, q1, p_init1, p_init2;

    logic [RW-1:0]              rx_sat, ry_sat;
    logic [CMP_W-1:0]           cfg_ext, cfg_sat;

    logic                       emit;
    logic signed [COORD_W-1:0]  cxs, cys, xs, ys, rxs;
    logic signed [COORD_W-1:0]  col_r, col_l, row_lo, row_up;
    logic [3:0]                 mask_next;

    function automatic logic signed [DEC_W-1:0] qtrunc(input logic signed [DEC_W-1:0] q);
        logic signed [DEC_W-1:0] biased;
        biased = q + DEC_W'(3);
        return q[DEC_W-1] ? (biased >>> 2) : (q >>> 2);
    endfunction

    function automatic logic on_surf(input logic signed [COORD_W-1:0] col,
                                     input logic signed [COORD_W-1:0] row,
                                     input logic [SW_W-1:0] w,
                                     input logic [SW_W-1:0] h);
        return !col[COORD_W-1] && !row[COORD_W-1] &&
               (CMP_W'(col[COORD_W-2:0]) < CMP_W'(w)) &&
               (CMP_W'(row[COORD_W-2:0]) < CMP_W'(h));
    endfunction

    assign rx_sat = (RCMP_W'(radius_x) > RCMP_W'(RADIUS_MAX)) ? RW'(RADIUS_MAX) : radius_x;
    assign ry_sat = (RCMP_W'(radius_y) > RCMP_W'(RADIUS_MAX)) ? RW'(RADIUS_MAX) : radius_y;

    assign cfg_ext = CMP_W'(cfg_wdata);
    assign cfg_sat = (cfg_ext > CMP_W'(SURFACE_MAX)) ? CMP_W'(SURFACE_MAX) : cfg_ext;

    // operand extensions
    assign rx_m   = $signed({{(MUL_W-RW){1'b0}}, rx_reg});
    assign ry_m   = $signed({{(MUL_W-RW){1'b0}}, ry_reg});
    assign rx2_m  = $signed({{(MUL_W-2*RW){1'b0}}, rx2_reg});
    assign ry2_m  = $signed({{(MUL_W-2*RW){1'b0}}, ry2_reg});
    assign x2p1_m = $signed({{(MUL_W-XY_W-1){x_reg[XY_W-1]}}, x_reg, 1'b1});
    assign ym1_m  = $signed({{(MUL_W-XY_W){y_reg[XY_W-1]}}, y_reg}) - MUL_W'(1);
    assign prod_m = prod_reg[MUL_W-1:0];

    always_comb begin
        unique case (ctrl.op)
            OP_MUL_RXRX:   begin mul_a = rx_m;   mul_b = rx_m;   end
            OP_MUL_RYRY:   begin mul_a = ry_m;   mul_b = ry_m;   end
            OP_MUL_RX2RY:  begin mul_a = rx2_m;  mul_b = ry_m;   end
            OP_MUL_X:      begin mul_a = x2p1_m; mul_b = x2p1_m; end
            OP_MUL_RY2P:   begin mul_a = ry2_m;  mul_b = prod_m; end
            OP_MUL_Y:      begin mul_a = ym1_m;  mul_b = ym1_m;  end
            OP_MUL_RX2P:   begin mul_a = rx2_m;  mul_b = prod_m; end
            OP_MUL_RX2RY2: begin mul_a = rx2_m;  mul_b = ry2_m;  end
            default:       begin mul_a = '0;     mul_b = '0;     end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign prod_next = mul_p[DEC_W-1:0];

    // decision arithmetic
    assign rx2_d   = $signed({{(DEC_W-2*RW){1'b0}}, rx2_reg});
    assign ry2_d   = $signed({{(DEC_W-2*RW){1'b0}}, ry2_reg});
    assign rx2x2   = $signed({{(SLOPE_W-2*RW-1){1'b0}}, rx2_reg, 1'b0});
    assign ry2x2   = $signed({{(SLOPE_W-2*RW-1){1'b0}}, ry2_reg, 1'b0});
    assign px_next = px_reg + ry2x2;
    assign py_next = py_reg - rx2x2;
    assign px_nd   = {{(DEC_W-SLOPE_W){px_next[SLOPE_W-1]}}, px_next};
    assign py_nd   = {{(DEC_W-SLOPE_W){py_next[SLOPE_W-1]}}, py_next};
    assign prod_x4 = prod_reg <<< 2;

    assign p1_lo = p_reg + ry2_d + px_nd;
    assign p1_hi = p_reg + ry2_d + px_nd - py_nd;
    assign p2_hi = p_reg + rx2_d - py_nd;
    assign p2_lo = p_reg + rx2_d - py_nd + px_nd;

    // 4*ry^2 - 4*rx^2*ry + rx^2 in quarter units
    assign q1      = (ry2_d <<< 2) - prod_x4 + rx2_d;
    assign p_init1 = qtrunc(q1);
    assign p_init2 = qtrunc(acc_reg - prod_x4);

    assign status.zero_rad = (rx_reg == '0) || (ry_reg == '0);
    assign status.r1_end   = !(px_reg < py_reg) || (n_reg >= N_W'(CAP));
    assign status.r2_end   = y_reg[XY_W-1] || (y_reg == '0) || (n_reg >= N_W'(CAP));
    assign status.out_free = !m_valid_reg || m_tready;

    assign emit = ctrl.exec && ((ctrl.op == OP_STEP1) || (ctrl.op == OP_STEP2) ||
                                (ctrl.op == OP_EMIT_FINAL) || (ctrl.op == OP_EMIT_ZERO));

    // result coordinates and clipping
    assign cxs = $signed({{(COORD_W-CW){1'b0}}, cx_reg});
    assign cys = $signed({{(COORD_W-CW){1'b0}}, cy_reg});
    assign xs  = {{(COORD_W-XY_W){x_reg[XY_W-1]}}, x_reg};
    assign ys  = {{(COORD_W-XY_W){y_reg[XY_W-1]}}, y_reg};
    assign rxs = $signed({{(COORD_W-RW){1'b0}}, rx_reg});

    always_comb begin
        col_r     = cxs + xs;
        col_l     = cxs - xs;
        row_lo    = cys + ys;
        row_up    = cys - ys;
        mask_next = '0;
        unique case (ctrl.op)
            OP_EMIT_FINAL: begin
                col_r        = cxs + rxs;
                col_l        = cxs - rxs;
                row_lo       = cys;
                row_up       = cys;
                mask_next[0] = on_surf(col_r, row_lo, width_reg, height_reg);
                mask_next[1] = on_surf(col_l, row_lo, width_reg, height_reg);
            end
            OP_EMIT_ZERO: begin
                col_r  = '0;
                col_l  = '0;
                row_lo = '0;
                row_up = '0;
            end
            default: begin
                mask_next[0] = on_surf(col_r, row_lo, width_reg, height_reg);
                mask_next[1] = on_surf(col_l, row_lo, width_reg, height_reg);
                mask_next[2] = on_surf(col_r, row_up, width_reg, height_reg);
                mask_next[3] = on_surf(col_l, row_up, width_reg, height_reg);
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            width_reg   <= SW_W'(SURFACE_MAX);
            height_reg  <= SW_W'(SURFACE_MAX);
            n_reg       <= '0;
        end else begin
            if (cfg_we && (cfg_index == REG_SURF_WIDTH)) begin
                width_reg <= SW_W'(cfg_sat);
            end
            if (cfg_we && (cfg_index == REG_SURF_HEIGHT)) begin
                height_reg <= SW_W'(cfg_sat);
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (ctrl.exec && (ctrl.op == OP_MUL_RX2RY)) begin
                n_reg <= '0;
            end else if (ctrl.exec && ((ctrl.op == OP_STEP1) || (ctrl.op == OP_STEP2))) begin
                n_reg <= n_reg + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (ctrl.exec) begin
            unique case (ctrl.op)
                OP_LOAD: begin
                    cx_reg <= center_x;
                    cy_reg <= center_y;
                    rx_reg <= rx_sat;
                    ry_reg <= ry_sat;
                end
                OP_MUL_RXRX: begin
                    prod_reg <= prod_next;
                end
                OP_MUL_RYRY: begin
                    rx2_reg  <= prod_reg[2*RW-1:0];
                    prod_reg <= prod_next;
                end
                OP_MUL_RX2RY: begin
                    ry2_reg  <= prod_reg[2*RW-1:0];
                    prod_reg <= prod_next;
                    x_reg    <= '0;
                    y_reg    <= $signed({{(XY_W-RW){1'b0}}, ry_reg});
                    px_reg   <= '0;
                end
                OP_INIT1: begin
                    py_reg <= $signed({prod_reg[SLOPE_W-2:0], 1'b0});
                    p_reg  <= p_init1;
                end
                OP_STEP1: begin
                    x_reg  <= x_reg + XY_ONE;
                    px_reg <= px_next;
                    if (p_reg[DEC_W-1]) begin
                        p_reg <= p1_lo;
                    end else begin
                        y_reg  <= y_reg - XY_ONE;
                        py_reg <= py_next;
                        p_reg  <= p1_hi;
                    end
                end
                OP_MUL_X, OP_MUL_RY2P, OP_MUL_RX2P: begin
                    prod_reg <= prod_next;
                end
                OP_MUL_Y: begin
                    acc_reg  <= prod_reg;
                    prod_reg <= prod_next;
                end
                OP_MUL_RX2RY2: begin
                    acc_reg  <= acc_reg + prod_x4;
                    prod_reg <= prod_next;
                end
                OP_INIT2: begin
                    p_reg <= p_init2;
                end
                OP_STEP2: begin
                    y_reg  <= y_reg - XY_ONE;
                    py_reg <= py_next;
                    if (!p_reg[DEC_W-1] && (p_reg != '0)) begin
                        p_reg <= p2_hi;
                    end else begin
                        x_reg  <= x_reg + XY_ONE;
                        px_reg <= px_next;
                        p_reg  <= p2_lo;
                    end
                end
                default: begin
                end
            endcase
        end
        if (emit) begin
            right_reg <= col_r;
            left_reg  <= col_l;
            lower_reg <= row_lo;
            upper_reg <= row_up;
            mask_reg  <= mask_next;
            last_reg  <= (ctrl.op == OP_EMIT_FINAL) || (ctrl.op == OP_EMIT_ZERO);
        end
    end

    assign m_tvalid         = m_valid_reg;
    assign right_col        = right_reg;
    assign left_col         = left_reg;
    assign lower_row        = lower_reg;
    assign upper_row        = upper_reg;
    assign point_mask       = mask_reg;
    assign last_point_group = last_reg;

endmodule

/* rtl/core/midpoint_ellipse_outline_top.sv */
// Midpoint ellipse outline generator: one request in, one beat per outline step out.
// A request beat carries a center and two radii. The block walks region 1 and then
// region 2 of the midpoint ellipse algorithm and sends one beat per step with the
// four mirrored points and a mask of those inside the configured surface, then a
// final beat (tlast) with the two points at center +/- radius_x on the center row.
// A zero radius gives a single empty beat with tlast. A microcoded sequencer drives
// one shared 14x14 multiplier through the setup, the region 1 steps, the region 2
// setup, the region 2 steps and the final beat, in that order; a step that emits a
// beat stalls while the result register holds a beat the consumer has not taken.
// A new request is accepted once the sequencer is back at its first step; the
// result register lets the last beat wait for the consumer while the next request
// is taken. Surface size registers are written through the cfg port; the user must
// write them only while the block is idle, as the block itself does not enforce it.
module midpoint_ellipse_outline_top
    import mpe_pkg::*;
#(
    parameter int RADIUS_MAX  = 31,
    parameter int SURFACE_MAX = 4096
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // center_x, center_y, radius_x, radius_y
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // right_col, left_col, lower_row, upper_row,
                                             // point_mask
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SURF_W-1:0]     cfg_wdata
);

    dp_ctrl_t   ctrl;
    dp_status_t status;

    logic signed [COORD_W-1:0] right_col, left_col, lower_row, upper_row;
    logic [3:0]                point_mask;

    mpe_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .ctrl     (ctrl),
        .s_tready (s_tready)
    );

    mpe_dp #(
        .RADIUS_MAX  (RADIUS_MAX),
        .SURFACE_MAX (SURFACE_MAX)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (ctrl),
        .status           (status),
        .center_x         (s_tdata[CW-1:0]),
        .center_y         (s_tdata[2*CW-1:CW]),
        .radius_x         (s_tdata[2*CW+RW-1:2*CW]),
        .radius_y         (s_tdata[2*CW+2*RW-1:2*CW+RW]),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .right_col        (right_col),
        .left_col         (left_col),
        .lower_row        (lower_row),
        .upper_row        (upper_row),
        .point_mask       (point_mask),
        .last_point_group (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W-M_MASK_LSB-4){1'b0}}, point_mask,
                      upper_row, lower_row, left_col, right_col};

endmodule

/* rtl/core/mpe_check.sv */
// Port-level checks for the ellipse outline block, bound to the top level.
module mpe_check
    import mpe_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // one request at a time
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // a pending mid-outline beat means the ellipse is still running
    a_busy_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("ready for a request before the final beat");

    // the final beat carries only two points
    a_final_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[M_MASK_LSB+3:M_MASK_LSB+2] == 2'b00)
        else $error("upper points flagged on final beat");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind midpoint_ellipse_outline_top mpe_check u_mpe_check (.*);
